// ===== hw/rtl/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder: command record passed from the
// front end to the back end, queue sizing and byte classification constants.
// No dependencies.
package u8u16_pkg;

	// Queue between front and back end
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Continuation bytes still expected
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// Payload masks of lead and continuation bytes
	localparam logic [7:0] LEAD_TWO_MASK   = 8'h1f;
	localparam logic [7:0] LEAD_THREE_MASK = 8'h0f;
	localparam logic [7:0] CONT_MASK       = 8'h3f;

	localparam logic [15:0] UNIT_MAX = 16'hffff;

	// Work for the back end from one accepted byte
	typedef struct packed {
		logic        has_unit;  // emit a code unit
		logic [15:0] unit;      // value of that code unit
		logic        has_term;  // emit the closing zero unit afterwards
	} cmd_t;

endpackage

// ===== hw/rtl/u8u16_front.sv =====
// Front end of the UTF-8 to UTF-16 decoder: classifies each byte, gathers
// multi-byte sequences and issues one command per byte that yields output.
// Depends on u8u16_pkg.
module u8u16_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              end_of_string,
	output logic              push,
	output u8u16_pkg::cmd_t   cmd
);

	logic [1:0]  pend_q;
	logic [11:0] part_q;
	logic [1:0]  pend_n;
	logic [11:0] part_n;
	logic [15:0] acc;
	logic        step_unit;
	logic [15:0] step_val;

	// Decode one byte against the open sequence
	always_comb begin
		pend_n    = pend_q;
		part_n    = part_q;
		step_unit = 1'b0;
		step_val  = 16'd0;
		acc       = {part_q[9:0], in_byte[5:0] & u8u16_pkg::CONT_MASK[5:0]};
		if (pend_q != u8u16_pkg::PEND_NONE) begin
			if (pend_q == u8u16_pkg::PEND_ONE) begin
				step_unit = 1'b1;
				step_val  = acc;
				pend_n    = u8u16_pkg::PEND_NONE;
				part_n    = 12'd0;
			end else begin
				part_n = acc[11:0];
				pend_n = u8u16_pkg::PEND_ONE;
			end
		end else if (in_byte < 8'h80) begin
			step_unit = 1'b1;
			step_val  = {8'd0, in_byte};
		end else if (in_byte inside {[8'hc0:8'hdf]}) begin
			part_n = {4'd0, in_byte & u8u16_pkg::LEAD_TWO_MASK};
			pend_n = u8u16_pkg::PEND_ONE;
		end else if (in_byte inside {[8'he0:8'hef]}) begin
			part_n = {4'd0, in_byte & u8u16_pkg::LEAD_THREE_MASK};
			pend_n = u8u16_pkg::PEND_TWO;
		end
	end

	// Build the command; flush a cut-short sequence at end of string
	always_comb begin
		cmd.has_unit = step_unit;
		cmd.unit     = step_val;
		cmd.has_term = end_of_string;
		if (end_of_string && pend_n != u8u16_pkg::PEND_NONE) begin
			cmd.has_unit = 1'b1;
			cmd.unit     = (pend_n == u8u16_pkg::PEND_ONE) ? {part_n[9:0], 6'd0}
			                                               : {part_n[3:0], 12'd0};
		end
	end

	assign push = accept && (cmd.has_unit || cmd.has_term);

	// Advance the sequence state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= u8u16_pkg::PEND_NONE;
			part_q <= 12'd0;
		end else if (accept) begin
			if (end_of_string) begin
				pend_q <= u8u16_pkg::PEND_NONE;
				part_q <= 12'd0;
			end else begin
				pend_q <= pend_n;
				part_q <= part_n;
			end
		end
	end

endmodule

// ===== hw/rtl/u8u16_fifo.sv =====
// Short command queue between the front and back end of the decoder.
// Depends on u8u16_pkg.
module u8u16_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8u16_pkg::cmd_t   push_cmd,
	input  logic              pop,
	output u8u16_pkg::cmd_t   head,
	output logic              not_empty,
	output logic              full
);

	u8u16_pkg::cmd_t                    mem_q [u8u16_pkg::QUEUE_DEPTH];
	logic [u8u16_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [u8u16_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [u8u16_pkg::QUEUE_CW-1:0]     count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == u8u16_pkg::QUEUE_CW'(u8u16_pkg::QUEUE_DEPTH));

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/u8u16_back.sv =====
// Back end of the decoder: plays queued commands out as result beats,
// keeps the saturating unit count and drives the output register.
// Depends on u8u16_pkg.
module u8u16_back (
	input  logic              clk,
	input  logic              arst_n,
	input  u8u16_pkg::cmd_t   head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       code_unit,
	output logic [15:0]       unit_total,
	output logic              is_terminator
);

	logic        valid_q;
	logic        phase_q;
	logic [15:0] count_q;
	logic [15:0] unit_q;
	logic [15:0] total_q;
	logic        term_q;
	logic        load;
	logic        emit_unit;
	logic [15:0] count_inc;

	assign load      = head_valid && (!valid_q || out_ready);
	assign emit_unit = head.has_unit && !phase_q;
	assign pop       = load && (!emit_unit || !head.has_term);
	assign count_inc = (count_q != u8u16_pkg::UNIT_MAX) ? count_q + 16'd1 : count_q;

	// Hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
			count_q <= 16'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q <= 1'b0;
			end else if (load) begin
				phase_q <= 1'b1;
			end
			if (load) begin
				count_q <= emit_unit ? count_inc : 16'd0;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (load) begin
			unit_q  <= emit_unit ? head.unit : 16'd0;
			total_q <= count_inc;
			term_q  <= !emit_unit;
		end
	end

	assign out_valid     = valid_q;
	assign code_unit     = unit_q;
	assign unit_total    = total_q;
	assign is_terminator = term_q;

endmodule

// ===== hw/rtl/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder: front end, command queue, back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo, u8u16_back.
//
//  channel | dir | tdata                                  | tlast
//  s_      | in  | [7:0] in_byte                          | end_of_string
//  m_      | out | [15:0] code_unit, [31:16] unit_total   | is_terminator
//
// One byte is accepted per cycle while the four-entry command queue has room.
// The back end issues each output beat on its own load; a byte ending the string
// with a unit before its terminator gives a unit beat, then a terminator beat.
// A result is registered first in the command queue and then in the back-end
// output register before it is presented on m_tdata.
// Reset clears sequence state, queue and unit count; m_tready low stalls the
// back end, and the queue fills before s_tready drops.
module utf8_to_utf16_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] unit_total
	output logic        m_tlast    // is_terminator
);

	u8u16_pkg::cmd_t push_cmd;
	u8u16_pkg::cmd_t head;
	logic            push;
	logic            pop;
	logic            not_empty;
	logic            full;
	logic            accept;
	logic [15:0]     code_unit;
	logic [15:0]     unit_total;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	u8u16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (s_tdata),
		.end_of_string (s_tlast),
		.push          (push),
		.cmd           (push_cmd)
	);

	u8u16_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	u8u16_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (not_empty),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.code_unit     (code_unit),
		.unit_total    (unit_total),
		.is_terminator (m_tlast)
	);

	assign m_tdata = {unit_total, code_unit};

endmodule
